// File: hw/rtl/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
package bpa_pkg;

  localparam int TOP_ORDER  = 8;
  localparam int NUM_ORDERS = 9;
  localparam int OW         = 4;
  localparam int ADDR_W     = 20;
  localparam int SIZE_W     = 21;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OOM = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC, S_SRCH, S_SPL, S_SPL2, S_SPL3, S_AOK, S_FCHK,
    S_MRG, S_MRG2, S_MRG3, S_MRG4, S_E0, S_E1, S_E2, S_E3, S_E4, S_P0, S_P1
  } st_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_LATCH, OP_DEC, OP_SRCH, OP_SPL2, OP_SPL3, OP_AOK,
    OP_FCHK, OP_MRG, OP_MRG2, OP_MRG3, OP_MRG4, OP_E0, OP_E1, OP_E2, OP_E3,
    OP_E4, OP_P0, OP_P1
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   zero_ord;
    logic   clr_free;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic dec_bad;
    logic is_free;
    logic srch_hit;
    logic srch_end;
    logic split_more;
    logic b_oob;
    logic fchk_bad;
    logic mrg_go;
    logic mrg_ok;
    logic pv_nil;
    logic nx_nil;
    logic tail_nil;
  } dp_sts_t;

endpackage

// File: hw/rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bpa_ctrl.sv
// Sequencer of the buddy page allocator: list erase and push as subroutines.
module bpa_ctrl import bpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output logic    busy,
  output dp_cmd_t cmd
);

  st_t state_r, state_nxt;
  st_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_INIT: if (sts.init_last) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = S_DEC;
      S_DEC: begin
        if (sts.dec_bad) state_nxt = S_IDLE;
        else if (sts.is_free) state_nxt = S_FCHK;
        else state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (sts.srch_hit) state_nxt = S_SPL;
        else if (sts.srch_end) state_nxt = S_IDLE;
      end
      S_SPL: begin
        state_nxt = S_E0;
        ret_nxt   = sts.split_more ? S_SPL2 : S_AOK;
      end
      S_SPL2: begin
        state_nxt = S_P0;
        ret_nxt   = S_SPL3;
      end
      S_SPL3: begin
        if (sts.b_oob) begin
          state_nxt = S_E0;
          ret_nxt   = S_AOK;
        end else begin
          state_nxt = S_P0;
          ret_nxt   = S_SPL;
        end
      end
      S_AOK: state_nxt = S_IDLE;
      S_FCHK: begin
        if (sts.fchk_bad) state_nxt = S_IDLE;
        else begin
          state_nxt = S_P0;
          ret_nxt   = S_MRG;
        end
      end
      S_MRG: state_nxt = sts.mrg_go ? S_MRG2 : S_IDLE;
      S_MRG2: begin
        if (sts.mrg_ok) begin
          state_nxt = S_E0;
          ret_nxt   = S_MRG3;
        end else state_nxt = S_IDLE;
      end
      S_MRG3: begin
        state_nxt = S_E0;
        ret_nxt   = S_MRG4;
      end
      S_MRG4: begin
        state_nxt = S_P0;
        ret_nxt   = S_MRG;
      end
      S_E0: state_nxt = S_E1;
      S_E1: state_nxt = sts.pv_nil ? S_E3 : S_E2;
      S_E2: state_nxt = S_E3;
      S_E3: state_nxt = sts.nx_nil ? ret_r : S_E4;
      S_E4: state_nxt = ret_r;
      S_P0: state_nxt = sts.tail_nil ? ret_r : S_P1;
      S_P1: state_nxt = ret_r;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NOP;
    cmd.zero_ord = 1'b0;
    cmd.clr_free = 1'b0;
    unique case (state_r)
      S_INIT: cmd.op = OP_INIT;
      S_IDLE: cmd.op = start ? OP_LATCH : OP_NOP;
      S_DEC:  cmd.op = OP_DEC;
      S_SRCH: cmd.op = OP_SRCH;
      S_SPL:  cmd.op = OP_NOP;
      S_SPL2: cmd.op = OP_SPL2;
      S_SPL3: cmd.op = OP_SPL3;
      S_AOK:  cmd.op = OP_AOK;
      S_FCHK: cmd.op = OP_FCHK;
      S_MRG:  cmd.op = OP_MRG;
      S_MRG2: cmd.op = OP_MRG2;
      S_MRG3: cmd.op = OP_MRG3;
      S_MRG4: cmd.op = OP_MRG4;
      S_E0:   cmd.op = OP_E0;
      S_E1: begin
        cmd.op = OP_E1;
        // upper buddy loses its head order; the granted block goes non-free
        cmd.zero_ord = (ret_r == S_MRG4);
        cmd.clr_free = (ret_r == S_AOK);
      end
      S_E2:   cmd.op = OP_E2;
      S_E3:   cmd.op = OP_E3;
      S_E4:   cmd.op = OP_E4;
      S_P0:   cmd.op = OP_P0;
      S_P1:   cmd.op = OP_P1;
      default: cmd.op = OP_NOP;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hw/rtl/bpa_dp.sv
// Datapath of the buddy page allocator: page table RAM, list heads and tails.
module bpa_dp import bpa_pkg::*; #(
  parameter int NUM_PAGES  = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic              in_cmd,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_block_address,
  input  logic              cfg_we,
  input  logic [OW-1:0]     cfg_wdata,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_granted_address,
  output logic [OW-1:0]     out_block_order_out,
  output logic [1:0]        out_status,
  output dp_sts_t           sts
);

  localparam int PW   = $clog2(NUM_PAGES);
  localparam int LW   = $clog2(NUM_PAGES + 1);
  localparam int SW   = LW + 10;
  localparam int WW   = OW + 2 + 2 * LW;
  localparam int N_HI = 2 * LW - 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);
  localparam logic [SW-1:0] NPS = SW'(NUM_PAGES);

  // page word: order, free, listed, next, prev
  logic          we;
  logic [PW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;

  logic [OW-1:0] rd_ord;
  logic          rd_free, rd_inl;
  logic [LW-1:0] rd_nxt, rd_prv;

  logic              cmd_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [4:0]        ord_r;
  logic [OW-1:0]     cur_r, e_o_r, mbo_r;
  logic [LW-1:0]     page_r, buddy_r, hi_r, lo_r, pt_r, e_nx_r, e_pv_r;
  logic [LW-1:0]     ic_r, nh_r;
  logic [LW-1:0]     head_r [NUM_ORDERS];
  logic [LW-1:0]     tail_r [NUM_ORDERS];
  logic              ov_r;
  logic [ADDR_W-1:0] oa_r;
  logic [OW-1:0]     oo_r;
  logic [1:0]        os_r;

  logic [4:0]        ordc;
  logic [ADDR_W-1:0] pg20;
  logic              pg_bad;
  logic [SW-1:0]     bsum, bx, icw;
  logic [OW-1:0]     lidx, io;
  logic [LW-1:0]     tl, inx, ipv;
  logic              ishead;
  logic              emit;
  logic [ADDR_W-1:0] e_addr;
  logic [OW-1:0]     e_ord;
  logic [1:0]        e_stat;

  function automatic logic [4:0] ceil_log2(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] m;
    logic [4:0]        n;
    m = s - SIZE_W'(1);
    n = 5'd0;
    for (int k = 0; k < SIZE_W; k++) begin
      if (m[k]) n = 5'(k + 1);
    end
    if (s == '0) n = 5'd0;
    return n;
  endfunction

  function automatic logic [OW-1:0] sat_ord(input logic [4:0] o);
    return (o > 5'd15) ? 4'd15 : o[OW-1:0];
  endfunction

  bpa_ram #(.W(WW), .D(NUM_PAGES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ord  = rdata[WW-1 -: OW];
  assign rd_free = rdata[2*LW+1];
  assign rd_inl  = rdata[2*LW];
  assign rd_nxt  = rdata[N_HI -: LW];
  assign rd_prv  = rdata[LW-1:0];

  always_comb begin
    logic [4:0] n;
    n      = ceil_log2(size_r);
    ordc   = (n > 5'(PAGE_SHIFT)) ? n - 5'(PAGE_SHIFT) : 5'd0;
    pg20   = addr_r >> PAGE_SHIFT;
    pg_bad = (pg20 >= ADDR_W'(NUM_PAGES));
    bsum   = SW'(page_r) + (SW'(1) << cur_r);
    bx     = SW'(page_r) ^ (SW'(1) << cur_r);
    icw    = SW'(ic_r);
    ishead = (ic_r == nh_r);
    // largest aligned block, of order TOP_ORDER at most, that still fits in memory
    io = '0;
    for (int k = 1; k <= TOP_ORDER; k++) begin
      if (((icw & ((SW'(1) << k) - SW'(1))) == '0) && (icw + (SW'(1) << k) <= NPS))
        io = OW'(k);
    end
    inx = ((io == OW'(TOP_ORDER)) && (icw + (SW'(2) << TOP_ORDER) <= NPS)) ?
          LW'(icw + (SW'(1) << TOP_ORDER)) : NIL;
    ipv = ((io == OW'(TOP_ORDER)) && (icw >= (SW'(1) << TOP_ORDER))) ?
          LW'(icw - (SW'(1) << TOP_ORDER)) : NIL;
  end

  always_comb begin
    case (cmd.op)
      OP_E1:   lidx = rd_ord;
      OP_E3:   lidx = e_o_r;
      OP_INIT: lidx = io;
      default: lidx = cur_r;
    endcase
  end

  assign tl = tail_r[lidx];

  always_comb begin
    sts.init_last  = (ic_r == LW'(NUM_PAGES - 1));
    sts.dec_bad    = cmd_r ? pg_bad : (ordc > {1'b0, mbo_r});
    sts.is_free    = (cmd_r == CMD_FREE);
    sts.srch_hit   = (tl != NIL);
    sts.srch_end   = (cur_r == mbo_r);
    sts.split_more = ({1'b0, cur_r} > ord_r);
    sts.b_oob      = (bsum >= NPS);
    sts.fchk_bad   = rd_free;
    sts.mrg_go     = (cur_r < mbo_r) && (bx < NPS);
    sts.mrg_ok     = rd_free && rd_inl && (rd_ord == cur_r);
    sts.pv_nil     = (rd_prv == NIL);
    sts.nx_nil     = (e_nx_r == NIL);
    sts.tail_nil   = (tl == NIL);
  end

  always_comb begin
    we    = 1'b0;
    waddr = page_r[PW-1:0];
    wdata = '0;
    raddr = page_r[PW-1:0];
    case (cmd.op)
      OP_INIT: begin
        we    = 1'b1;
        waddr = ic_r[PW-1:0];
        wdata = ishead ? {io, 1'b1, 1'b1, inx, ipv} : {OW'(0), 1'b1, 1'b0, NIL, NIL};
      end
      OP_DEC: raddr = pg20[PW-1:0];
      OP_MRG: raddr = bx[PW-1:0];
      OP_E1: begin
        we    = 1'b1;
        wdata = {cmd.zero_ord ? OW'(0) : rd_ord, rd_free & ~cmd.clr_free, 1'b0, NIL, NIL};
        raddr = rd_prv[PW-1:0];
      end
      OP_E2: begin
        we    = 1'b1;
        waddr = e_pv_r[PW-1:0];
        wdata = {rdata[WW-1:N_HI+1], e_nx_r, rdata[LW-1:0]};
      end
      OP_E3: raddr = e_nx_r[PW-1:0];
      OP_E4: begin
        we    = 1'b1;
        waddr = e_nx_r[PW-1:0];
        wdata = {rdata[WW-1:LW], e_pv_r};
      end
      OP_P0: begin
        we    = 1'b1;
        wdata = {cur_r, 1'b1, 1'b1, NIL, tl};
        raddr = tl[PW-1:0];
      end
      OP_P1: begin
        we    = 1'b1;
        waddr = pt_r[PW-1:0];
        wdata = {rdata[WW-1:N_HI+1], page_r, rdata[LW-1:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    emit   = 1'b0;
    e_addr = '0;
    e_ord  = '0;
    e_stat = STAT_OK;
    case (cmd.op)
      OP_DEC: if (sts.dec_bad) begin
        emit   = 1'b1;
        e_ord  = cmd_r ? OW'(0) : sat_ord(ordc);
        e_stat = STAT_BAD;
      end
      OP_SRCH: if (!sts.srch_hit && sts.srch_end) begin
        emit   = 1'b1;
        e_ord  = sat_ord(ord_r);
        e_stat = STAT_OOM;
      end
      OP_AOK: begin
        emit   = 1'b1;
        e_addr = ADDR_W'({page_r, {PAGE_SHIFT{1'b0}}});
        e_ord  = sat_ord(ord_r);
      end
      OP_FCHK: if (rd_free) begin
        emit   = 1'b1;
        e_stat = STAT_BAD;
      end
      OP_MRG: if (!sts.mrg_go) begin
        emit  = 1'b1;
        e_ord = sat_ord(ord_r);
      end
      OP_MRG2: if (!sts.mrg_ok) begin
        emit  = 1'b1;
        e_ord = sat_ord(ord_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbo_r <= OW'(TOP_ORDER);
      ic_r  <= '0;
      nh_r  <= '0;
      ov_r  <= 1'b0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        head_r[k] <= NIL;
        tail_r[k] <= NIL;
      end
    end else begin
      ov_r <= emit;
      if (cfg_we) begin
        mbo_r <= (cfg_wdata > OW'(TOP_ORDER)) ? OW'(TOP_ORDER) : cfg_wdata;
      end
      case (cmd.op)
        OP_INIT: begin
          ic_r <= ic_r + LW'(1);
          if (ishead) begin
            nh_r <= LW'(icw + (SW'(1) << io));
            if (head_r[lidx] == NIL) head_r[lidx] <= ic_r;
            tail_r[lidx] <= ic_r;
          end
        end
        OP_E1: if (rd_prv == NIL) head_r[lidx] <= rd_nxt;
        OP_E3: if (e_nx_r == NIL) tail_r[lidx] <= e_pv_r;
        OP_P0: begin
          if (tl == NIL) head_r[lidx] <= page_r;
          tail_r[lidx] <= page_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oa_r <= e_addr;
      oo_r <= e_ord;
      os_r <= e_stat;
    end
    case (cmd.op)
      OP_LATCH: begin
        cmd_r  <= in_cmd;
        size_r <= in_request_size;
        addr_r <= in_block_address;
      end
      OP_DEC: begin
        ord_r  <= ordc;
        cur_r  <= ordc[OW-1:0];
        page_r <= LW'(pg20);
      end
      OP_SRCH: begin
        if (sts.srch_hit) page_r <= tl;
        else if (!sts.srch_end) cur_r <= cur_r + OW'(1);
      end
      OP_SPL2: cur_r <= cur_r - OW'(1);
      OP_SPL3: if (!sts.b_oob) page_r <= LW'(bsum);
      OP_FCHK: begin
        ord_r <= {1'b0, rd_ord};
        cur_r <= rd_ord;
      end
      OP_MRG: buddy_r <= LW'(bx);
      OP_MRG2: begin
        page_r <= (page_r < buddy_r) ? page_r : buddy_r;
        hi_r   <= (page_r < buddy_r) ? buddy_r : page_r;
      end
      OP_MRG3: begin
        lo_r   <= page_r;
        page_r <= hi_r;
      end
      OP_MRG4: begin
        page_r <= lo_r;
        cur_r  <= cur_r + OW'(1);
      end
      OP_E1: begin
        e_o_r  <= rd_ord;
        e_nx_r <= rd_nxt;
        e_pv_r <= rd_prv;
      end
      OP_P0: pt_r <= tl;
      default: ;
    endcase
  end

  assign out_valid           = ov_r;
  assign out_granted_address = oa_r;
  assign out_block_order_out = oo_r;
  assign out_status          = os_r;

endmodule

// File: hw/rtl/buddy_page_allocator_top.sv
// Top level of the buddy page allocator.
// A command word is taken when start is high and busy is low: in_cmd selects
// allocate (size in in_request_size) or free (in_block_address). Exactly one
// result word follows, shown for a single cycle with out_valid high: the
// granted address, the block order and a status code. The receiver cannot
// stall; out_valid is high for that one cycle only, and the result registers
// keep the word until the next one. Commands are handled one at a time by a
// sequencer over a single page table RAM (one write and one registered read a
// cycle). A request may be rejected at decode, a free of a free page is
// refused and an out-of-memory allocate ends after the search; an allocate
// erases and pushes list entries for each split level, a free for each merge
// step. The result shows in the cycle after the last busy cycle, with busy
// already low, so the next word can be taken in that same cycle. After reset
// the block runs a clearing pass over all NUM_PAGES pages that lays all memory
// out as maximal free blocks; busy stays high meanwhile. cfg_we writes
// max_block_order (values above 8 saturate) while idle: the user must keep to
// that, since the block does not check busy on a write.
module buddy_page_allocator_top import bpa_pkg::*; #(
  parameter int NUM_PAGES  = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_block_address,
  input  logic              cfg_we,
  input  logic [OW-1:0]     cfg_wdata,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_granted_address,
  output logic [OW-1:0]     out_block_order_out,
  output logic [1:0]        out_status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  bpa_dp #(.NUM_PAGES(NUM_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_cmd              (in_cmd),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_granted_address (out_granted_address),
    .out_block_order_out (out_block_order_out),
    .out_status          (out_status),
    .sts                 (sts)
  );

endmodule

// File: hw/rtl/bpa_chk.sv
// Port-level checks of the buddy page allocator, bound to the top level.
module bpa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [19:0] out_granted_address,
  input logic [1:0]  out_status
);

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy while result shown");

  a_busy_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("command word taken but not busy");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 2'd0) |-> (out_granted_address == 20'd0))
    else $error("failed request with non-zero address");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("undefined status code");

endmodule

bind buddy_page_allocator_top bpa_chk u_chk (.*);
